FILE: sv/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg
// Types and constants shared by the 3x3 Gaussian blur block.
// ----------------------------------------------------------------------------
package gb3_pkg;

    localparam int unsigned CFG_WIDTH_BITS  = 12;
    localparam int unsigned CFG_HEIGHT_BITS = 13;
    localparam int unsigned CFG_DATA_BITS   = 13;

    localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [0:0] {
        CFG_IDX_WIDTH  = 1'b0,
        CFG_IDX_HEIGHT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  filtered_value;
        logic [10:0] centre_column;
        logic [11:0] centre_row;
        logic        frame_end;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] upper;
        logic [7:0] middle;
    } t_line_word;

    typedef struct packed {
        logic        valid;
        logic        emit;
        logic [10:0] centre_column;
        logic [11:0] centre_row;
        logic        frame_end;
    } t_win_ctrl;

endpackage

FILE: sv/gb3_line_mem.sv
// ----------------------------------------------------------------------------
// gb3_line_mem
// Line store holding the two previous rows, one word per column.
// ----------------------------------------------------------------------------
module gb3_line_mem #(
    parameter int unsigned DEPTH = 2048
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  gb3_pkg::t_line_word        i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output gb3_pkg::t_line_word        o_rdata
);

    gb3_pkg::t_line_word r_mem [DEPTH];
    gb3_pkg::t_line_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/gb3_window.sv
// ----------------------------------------------------------------------------
// gb3_window
// 3x3 window of two held columns plus the current one, and the kernel sum.
// ----------------------------------------------------------------------------
module gb3_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gb3_pkg::t_win_ctrl   i_ctrl,
    input  logic [7:0]           i_top,
    input  logic [7:0]           i_mid,
    input  logic [7:0]           i_px,
    output logic                 o_push,
    output gb3_pkg::t_pix_out    o_data
);

    logic [7:0]  r_win [2][3];
    logic [11:0] sum;

    always_comb begin
        sum = 12'(r_win[0][0]) + {3'b0, r_win[1][0], 1'b0} + 12'(i_top)
            + {3'b0, r_win[0][1], 1'b0} + {2'b0, r_win[1][1], 2'b0}
            + {3'b0, i_mid, 1'b0}
            + 12'(r_win[0][2]) + {3'b0, r_win[1][2], 1'b0} + 12'(i_px);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[c][r] <= 8'd0;
                end
            end
        end else if (i_ctrl.valid) begin
            r_win[0][0] <= r_win[1][0];
            r_win[0][1] <= r_win[1][1];
            r_win[0][2] <= r_win[1][2];
            r_win[1][0] <= i_top;
            r_win[1][1] <= i_mid;
            r_win[1][2] <= i_px;
        end
    end

    assign o_push                = i_ctrl.valid && i_ctrl.emit;
    assign o_data.filtered_value = sum[11:4];
    assign o_data.centre_column  = i_ctrl.centre_column;
    assign o_data.centre_row     = i_ctrl.centre_row;
    assign o_data.frame_end      = i_ctrl.frame_end;

endmodule

FILE: sv/gb3_out_fifo.sv
// ----------------------------------------------------------------------------
// gb3_out_fifo
// Two-entry result queue that decouples the filter from the receiver.
// ----------------------------------------------------------------------------
module gb3_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gb3_pkg::t_pix_out    i_data,
    input  logic                 i_pop,
    output gb3_pkg::t_pix_out    o_data,
    output logic [1:0]           o_count
);

    gb3_pkg::t_pix_out r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    assign o_data  = r_q[r_rp];
    assign o_count = r_cnt;

endmodule

FILE: sv/gaussian_blur_3x3_gray.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_gray
// 3x3 Gaussian smoothing (1-2-1 kernel, sum shifted right by four) of a grey
// pixel stream in raster order, giving interior pixels only.
// ----------------------------------------------------------------------------
// Pixels enter on the i_valid / o_ready channel, one transaction per pixel;
// frame_start places a pixel at column 0, row 0. Results leave on the
// o_valid / i_ready channel with their column, row and an end-of-frame mark.
// Border pixels give no result. Image width and height are written on the
// configuration channel, which is always ready; the user is to write them
// only while the block is idle, and the block itself does not enforce this.
// A pixel is accepted every cycle while o_ready is high. Its result, if any,
// passes the line store read stage and the result queue register to o_valid.
// The line store is one memory of two pixels per column, read at the
// current column and written back in the next cycle, with forwarding when a
// restart by frame_start returns to the column just written.
// A two-entry result queue lets input continue while a result waits; when
// the receiver stalls, o_ready drops once the queue and the stage before it
// hold two transactions between them and no result leaves in that cycle.
// Reset clears the counters, window and queue and restores the default size
// of 640 by 480; the line store needs no clearing.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_gray #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  gb3_pkg::t_pix_in                     i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output gb3_pkg::t_pix_out                    o_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  gb3_pkg::t_cfg_index                  i_cfg_index,
    input  logic [gb3_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

    logic [gb3_pkg::CFG_WIDTH_BITS-1:0]  r_width;
    logic [gb3_pkg::CFG_HEIGHT_BITS-1:0] r_height;
    logic [CW-1:0]                       r_col;
    logic [RW-1:0]                       r_row;

    logic [31:0]   w32;
    logic [31:0]   h32;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic          in_acc;
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
    logic [RW-1:0] r0;
    logic [RW-1:0] r1;
    logic [RW-1:0] r2;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [AW-1:0] addr0;

    gb3_pkg::t_win_ctrl  r_s1;
    gb3_pkg::t_win_ctrl  n_s1;
    logic [AW-1:0]       r_s1_addr;
    logic [7:0]          r_s1_px;
    logic                r_fwd;
    gb3_pkg::t_line_word r_fwd_data;

    gb3_pkg::t_line_word mem_q;
    gb3_pkg::t_line_word mem_wdata;
    logic [7:0]          top;
    logic [7:0]          mid;

    logic                push;
    gb3_pkg::t_pix_out   push_data;
    logic                pop;
    logic [1:0]          fifo_count;
    logic [2:0]          occ;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= gb3_pkg::WIDTH_RESET;
            r_height <= gb3_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gb3_pkg::CFG_IDX_WIDTH: begin
                    r_width <= i_cfg_data[gb3_pkg::CFG_WIDTH_BITS-1:0];
                end
                gb3_pkg::CFG_IDX_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width < 12'd3) begin
            w32 = 32'd3;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w32 = MAX_WIDTH;
        end else begin
            w32 = 32'(r_width);
        end
        if (r_height < 13'd3) begin
            h32 = 32'd3;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h32 = MAX_HEIGHT;
        end else begin
            h32 = 32'(r_height);
        end
        w_eff = CW'(w32);
        h_eff = RW'(h32);
    end

    assign occ     = {1'b0, fifo_count} + {2'b0, r_s1.valid};
    assign pop     = o_valid && i_ready;
    assign o_ready = (occ < 3'd2) || ((occ == 3'd2) && pop);
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        c0 = i_data.frame_start ? '0 : r_col;
        r0 = i_data.frame_start ? '0 : r_row;
        if (c0 >= w_eff) begin
            c1 = '0;
            r1 = r0 + RW'(1);
        end else begin
            c1 = c0;
            r1 = r0;
        end
        r2 = (r1 >= h_eff) ? '0 : r1;
        addr0 = c1[AW-1:0];

        n_col = c1 + CW'(1);
        n_row = r2;
        if (n_col >= w_eff) begin
            n_col = '0;
            n_row = r2 + RW'(1);
            if (n_row >= h_eff) begin
                n_row = '0;
            end
        end

        n_s1.valid         = in_acc;
        n_s1.emit          = (c1 >= CW'(2)) && (r2 >= RW'(2));
        n_s1.centre_column = 11'(c1 - CW'(1));
        n_s1.centre_row    = 12'(r2 - RW'(1));
        n_s1.frame_end     = (c1 == w_eff - CW'(1)) && (r2 == h_eff - RW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1.valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
                r_fwd <= r_s1.valid && (r_s1_addr == addr0);
            end
        end
        if (in_acc) begin
            r_s1.emit          <= n_s1.emit;
            r_s1.centre_column <= n_s1.centre_column;
            r_s1.centre_row    <= n_s1.centre_row;
            r_s1.frame_end     <= n_s1.frame_end;
            r_s1_addr          <= addr0;
            r_s1_px            <= i_data.pixel;
            r_fwd_data         <= mem_wdata;
        end
    end

    assign top              = r_fwd ? r_fwd_data.upper  : mem_q.upper;
    assign mid              = r_fwd ? r_fwd_data.middle : mem_q.middle;
    assign mem_wdata.upper  = mid;
    assign mem_wdata.middle = r_s1_px;

    gb3_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1_addr),
        .i_wdata (mem_wdata),
        .i_re    (in_acc),
        .i_raddr (addr0),
        .o_rdata (mem_q)
    );

    gb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_s1),
        .i_top   (top),
        .i_mid   (mid),
        .i_px    (r_s1_px),
        .o_push  (push),
        .o_data  (push_data)
    );

    gb3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_count (fifo_count)
    );

    assign o_valid = (fifo_count != 2'd0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (fifo_count == 2'd2)) |-> pop)
        else $error("Result queue written while full.");

    a_accept_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1.valid)
        else $error("Accepted transaction did not reach the line store stage.");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((push_data.centre_column != 11'd0) && (push_data.centre_row != 12'd0)))
        else $error("Result produced for a border pixel.");

endmodule

FILE: test/gaussian_blur_3x3_gray_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_gray_test
// Self-checking testbench for the 3x3 Gaussian blur of a grey pixel stream.
// ----------------------------------------------------------------------------
// A queue of pending transactions (pixels, size writes and pauses) is filled
// at the start and played out by a clocked driver with random gaps. A clocked
// monitor predicts every interior result as pixels are accepted and compares
// each result transaction, field by field, against the oldest prediction
// while the receiver stalls at random. Frames range from the smallest size
// to the start of the widest and the opening rows of the tallest, with
// sizes out of range or shrunk mid-frame, restarts and truncated frames.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_gray_test;

    localparam int unsigned LINE_MAX      = 2048;
    localparam int unsigned ROWS_MAX      = 4096;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_PIXELS = 1100;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_CONFIG,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind                          kind;
        gb3_pkg::t_pix_in                  pix;
        gb3_pkg::t_cfg_index               index;
        logic [gb3_pkg::CFG_DATA_BITS-1:0] data;
    } t_pending_op;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_valid     = 1'b0;
    logic                              o_ready;
    gb3_pkg::t_pix_in                  i_data      = '0;
    logic                              o_valid;
    logic                              i_ready     = 1'b0;
    gb3_pkg::t_pix_out                 o_data;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    gb3_pkg::t_cfg_index               i_cfg_index = gb3_pkg::CFG_IDX_WIDTH;
    logic [gb3_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    t_pending_op       pending_ops[$];
    gb3_pkg::t_pix_out blurred_q[$];
    int                results_outstanding = 0;

    // Predictor state.
    logic [gb3_pkg::CFG_WIDTH_BITS-1:0]  cur_width;
    logic [gb3_pkg::CFG_HEIGHT_BITS-1:0] cur_height;
    logic [7:0]                          older_row [LINE_MAX];
    logic [7:0]                          prev_row [LINE_MAX];
    logic [7:0]                          win_top [2];
    logic [7:0]                          win_mid [2];
    logic [7:0]                          win_bot [2];
    int unsigned                         col_cnt;
    int unsigned                         row_cnt;

    // Stimulus planning state.
    int unsigned plan_width      = 640;
    int unsigned plan_height     = 480;
    bit          restart_pending = 1'b0;
    int unsigned planned_pixels  = 0;

    int unsigned gap_left     = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    bit          send_burst   = 1'b0;
    bit          recv_burst   = 1'b0;

    int unsigned failures      = 0;
    int unsigned pixels_in     = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_done   = 0;
    int unsigned config_writes = 0;

    gaussian_blur_3x3_gray uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int unsigned clamp_size(input int unsigned value, input int unsigned hi);
        if (value < 3) begin
            return 3;
        end
        if (value > hi) begin
            return hi;
        end
        return value;
    endfunction

    function automatic int unsigned draw_wait(inout bit burst);
        if ($urandom_range(0, 99) < 2) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] draw_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_pixel(input logic [7:0] value, input bit start);
        t_pending_op op;
        op       = '0;
        op.kind  = OP_PIXEL;
        op.pix.pixel       = value;
        op.pix.frame_start = start || restart_pending;
        restart_pending    = 1'b0;
        pending_ops.push_back(op);
        planned_pixels++;
    endtask

    // A wider line would read store entries never written, so growth forces
    // the next pixel to restart the frame.
    task automatic queue_config(input gb3_pkg::t_cfg_index index,
                                input logic [gb3_pkg::CFG_DATA_BITS-1:0] data);
        t_pending_op op;
        int unsigned eff;
        op       = '0;
        op.kind  = OP_CONFIG;
        op.index = index;
        op.data  = data;
        pending_ops.push_back(op);
        if (index == gb3_pkg::CFG_IDX_WIDTH) begin
            eff = clamp_size(data[gb3_pkg::CFG_WIDTH_BITS-1:0], LINE_MAX);
            if (eff > plan_width) begin
                restart_pending = 1'b1;
            end
            plan_width = eff;
        end else begin
            plan_height = clamp_size(data, ROWS_MAX);
        end
    endtask

    task automatic queue_drain();
        t_pending_op op;
        op      = '0;
        op.kind = OP_DRAIN;
        pending_ops.push_back(op);
    endtask

    task automatic queue_frame(input bit start, input int unsigned length, input bit noisy);
        for (int unsigned n = 0; n < length; n++) begin
            queue_pixel(draw_pixel(),
                        (n == 0 && start) || (noisy && $urandom_range(0, 199) == 0));
        end
    endtask

    task automatic blur_predict(input gb3_pkg::t_pix_in pix);
        int unsigned       w;
        int unsigned       h;
        int unsigned       col;
        int unsigned       row;
        int unsigned       sum;
        logic [7:0]        top;
        logic [7:0]        mid;
        gb3_pkg::t_pix_out res;
        w = clamp_size(cur_width, LINE_MAX);
        h = clamp_size(cur_height, ROWS_MAX);
        if (pix.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) begin
            row_cnt = 0;
        end
        col = col_cnt;
        row = row_cnt;
        top = older_row[col];
        mid = prev_row[col];
        older_row[col] = mid;
        prev_row[col]  = pix.pixel;
        if (col >= 2 && row >= 2) begin
            sum = win_top[0] + 2 * win_top[1] + top
                + 2 * win_mid[0] + 4 * win_mid[1] + 2 * mid
                + win_bot[0] + 2 * win_bot[1] + pix.pixel;
            res.filtered_value = 8'(sum >> 4);
            res.centre_column  = 11'(col - 1);
            res.centre_row     = 12'(row - 1);
            res.frame_end      = (col == w - 1) && (row == h - 1);
            blurred_q.push_back(res);
        end
        win_top[0] = win_top[1];
        win_mid[0] = win_mid[1];
        win_bot[0] = win_bot[1];
        win_top[1] = top;
        win_mid[1] = mid;
        win_bot[1] = pix.pixel;
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) begin
                row = 0;
            end
        end
        col_cnt = col;
        row_cnt = row;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Driver: plays out the pending transactions in order.
    always @(posedge i_clk) begin
        logic        next_valid;
        logic        next_cfg_valid;
        t_pending_op op;
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_cfg_valid  <= 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            next_valid     = i_valid && !o_ready;
            next_cfg_valid = i_cfg_valid && !o_cfg_ready;
            if (!next_valid && !next_cfg_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() != 0) begin
                    op = pending_ops[0];
                    case (op.kind)
                        OP_PIXEL: begin
                            next_valid = 1'b1;
                            i_data     <= op.pix;
                            void'(pending_ops.pop_front());
                            gap_left   = draw_wait(send_burst);
                        end
                        OP_CONFIG: begin
                            next_cfg_valid = 1'b1;
                            i_cfg_index    <= op.index;
                            i_cfg_data     <= op.data;
                            void'(pending_ops.pop_front());
                            gap_left       = draw_wait(send_burst);
                        end
                        default: begin
                            if (results_outstanding == 0) begin
                                quiet_cycles++;
                            end else begin
                                quiet_cycles = 0;
                            end
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                quiet_cycles = 0;
                                void'(pending_ops.pop_front());
                            end
                        end
                    endcase
                end
            end
            i_valid     <= next_valid;
            i_cfg_valid <= next_cfg_valid;
        end
    end

    // Monitor: predicts on accepted pixels, checks accepted results.
    always @(posedge i_clk) begin
        gb3_pkg::t_pix_out want;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left = 0;
            cur_width  = gb3_pkg::WIDTH_RESET;
            cur_height = gb3_pkg::HEIGHT_RESET;
            col_cnt    = 0;
            row_cnt    = 0;
            for (int i = 0; i < 2; i++) begin
                win_top[i] = '0;
                win_mid[i] = '0;
                win_bot[i] = '0;
            end
            for (int i = 0; i < LINE_MAX; i++) begin
                older_row[i] = '0;
                prev_row[i]  = '0;
            end
            blurred_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                config_writes++;
                if (i_cfg_index == gb3_pkg::CFG_IDX_WIDTH) begin
                    cur_width = i_cfg_data[gb3_pkg::CFG_WIDTH_BITS-1:0];
                end else begin
                    cur_height = i_cfg_data[gb3_pkg::CFG_HEIGHT_BITS-1:0];
                end
            end
            if (i_valid && o_ready) begin
                pixels_in++;
                blur_predict(i_data);
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (blurred_q.size() == 0) begin
                    failures++;
                    $display("%0t: result mismatch, expected none, actual %p", $time, o_data);
                end else begin
                    want = blurred_q.pop_front();
                    check_field("filtered_value", want.filtered_value, o_data.filtered_value);
                    check_field("centre_column", want.centre_column, o_data.centre_column);
                    check_field("centre_row", want.centre_row, o_data.centre_row);
                    check_field("frame_end", want.frame_end, o_data.frame_end);
                    if (want.frame_end) begin
                        frames_done++;
                    end
                end
                stall_left = draw_wait(recv_burst);
            end
            i_ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
        results_outstanding <= blurred_q.size();
    end

    initial begin
        int unsigned directed_total;
        int unsigned frames;
        int unsigned pick;
        int unsigned area;

        // Smallest frame, saturated from below: all white, then an impulse
        // frame that follows on by wrapping without a restart.
        queue_config(gb3_pkg::CFG_IDX_WIDTH, 13'd0);
        queue_config(gb3_pkg::CFG_IDX_HEIGHT, 13'd1);
        for (int unsigned n = 0; n < 9; n++) begin
            queue_pixel(8'd255, n == 0);
        end
        for (int unsigned n = 0; n < 9; n++) begin
            queue_pixel((n == 4) ? 8'd255 : 8'd0, 1'b0);
        end
        queue_drain();

        // Stop part way along row two, then shrink width below the column and
        // height so that the row wraps; the upper width bit is ignored.
        queue_config(gb3_pkg::CFG_IDX_WIDTH, 13'd5);
        queue_config(gb3_pkg::CFG_IDX_HEIGHT, 13'd5);
        queue_frame(1'b1, 14, 1'b0);
        queue_drain();
        queue_config(gb3_pkg::CFG_IDX_WIDTH, 13'h1003);
        queue_config(gb3_pkg::CFG_IDX_HEIGHT, 13'd3);
        queue_frame(1'b0, 2, 1'b0);
        queue_drain();

        // Start of the first row of the widest frame and opening rows of the
        // tallest, each saturated from above in its large dimension.
        queue_config(gb3_pkg::CFG_IDX_WIDTH, 13'd4095);
        queue_config(gb3_pkg::CFG_IDX_HEIGHT, 13'd3);
        queue_frame(1'b1, LINE_MAX / 8, 1'b0);
        queue_drain();
        queue_config(gb3_pkg::CFG_IDX_WIDTH, 13'd2);
        queue_config(gb3_pkg::CFG_IDX_HEIGHT, 13'd8191);
        queue_frame(1'b1, 3 * 64, 1'b0);
        directed_total = planned_pixels;

        while (planned_pixels < directed_total + RANDOM_PIXELS) begin
            queue_drain();
            pick = $urandom_range(0, 3);
            if (pick == 0 || pick == 2) begin
                queue_config(gb3_pkg::CFG_IDX_WIDTH, ($urandom_range(0, 9) == 0) ?
                             13'($urandom_range(0, 2)) : 13'($urandom_range(3, 12)));
            end
            if (pick == 1 || pick == 2) begin
                queue_config(gb3_pkg::CFG_IDX_HEIGHT, ($urandom_range(0, 9) == 0) ?
                             13'($urandom_range(0, 2)) : 13'($urandom_range(3, 9)));
            end
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++) begin
                area = plan_width * plan_height;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    queue_frame(1'b1, area, 1'b1);
                end else if (pick < 9) begin
                    queue_frame(1'($urandom_range(0, 1)), $urandom_range(1, area - 1), 1'b1);
                end else begin
                    queue_frame(1'b0, area, 1'b1);
                end
                if ($urandom_range(0, 3) == 0) begin
                    queue_drain();
                end
            end
        end
        queue_drain();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
        if (blurred_q.size() != 0) begin
            failures += blurred_q.size();
            $display("%0t: %0d expected results never arrived", $time, blurred_q.size());
        end
        $display("Checked %0d results from %0d pixels, with %0d frames run to their last pixel.",
                 results_seen, pixels_in, frames_done);
        $display("Sizes were changed by %0d register writes, from 3 by 3 up to 2048 and 4096.",
                 config_writes);
        if (failures == 0) begin
            $display("gaussian_blur_3x3_gray regression: pass");
        end else begin
            $display("gaussian_blur_3x3_gray regression: fail");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("Timed out with %0d transactions still pending.", pending_ops.size());
        $display("gaussian_blur_3x3_gray regression: fail");
        $finish;
    end

endmodule

FILE: gaussian_blur_3x3_gray.f
sv/gb3_pkg.sv
sv/gb3_line_mem.sv
sv/gb3_window.sv
sv/gb3_out_fifo.sv
sv/gaussian_blur_3x3_gray.sv
test/gaussian_blur_3x3_gray_test.sv
